@@ sv/eti_pkg.sv @@
package eti_pkg;

    // Data format: signed fixed point, FRAC_BITS fractional bits
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;

    // Derived widths
    localparam int PROD_W  = 2 * DATA_WIDTH;       // exact product
    localparam int MAG_W   = PROD_W + 1;           // sum of two squares
    localparam int SUM_W   = PROD_W + 2;           // update sums before saturation
    localparam int BOUND_W = DATA_WIDTH - 1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BOUND = CFG_INDEX_W'(1);

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(256);
    localparam logic [BOUND_W-1:0]     BOUND_RESET    = BOUND_W'(64'd4 << FRAC_BITS);

    // Item queue between front and engine
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] start_real;
        logic signed [DATA_WIDTH-1:0] start_imag;
        logic signed [DATA_WIDTH-1:0] const_real;
        logic signed [DATA_WIDTH-1:0] const_imag;
        logic                         zero_limit;   // iteration limit is zero
    } eti_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } eti_q_status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_MUL,
        ENG_STEP,
        ENG_WAIT
    } eng_state_t;

    // Clamp a wide signed sum into the signed data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_data(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-DATA_WIDTH:0] upper;
        logic signed [DATA_WIDTH-1:0] res;
        upper = v[SUM_W-1:DATA_WIDTH-1];
        if ((&upper) || !(|upper))
        begin
            res = v[DATA_WIDTH-1:0];
        end
        else if (v[SUM_W-1])
        begin
            res = DATA_MIN;
        end
        else
        begin
            res = DATA_MAX;
        end
        return res;
    endfunction

endpackage

@@ sv/escape_time_iteration.sv @@
// The engine works on one point at a time; each iteration passes through the
// multiplier stage and then the update/escape-test stage.
// A two-entry queue lets new points be accepted while the engine iterates.
// Reset (rst_n, async, active low) empties front stage, queue and output and
// sets max_iterations to 256 and escape_bound to 4.0.
module escape_time_iteration (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]  start_real,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]  start_imag,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]  const_real,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]  const_imag,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [eti_pkg::COUNT_WIDTH-1:0]        escape_count,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [eti_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [eti_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic [eti_pkg::COUNT_WIDTH-1:0] max_iter_reg, max_iter_next;
    logic [eti_pkg::BOUND_W-1:0]     bound_reg, bound_next;
    logic                            push;
    logic                            pop;
    eti_pkg::eti_item_t              push_item;
    eti_pkg::eti_item_t              q_head;
    eti_pkg::eti_q_status_t          q_status;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_comb
    begin
        max_iter_next = max_iter_reg;
        bound_next    = bound_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                eti_pkg::CFG_MAX_ITER:
                begin
                    max_iter_next = cfg_data[eti_pkg::COUNT_WIDTH-1:0];
                end
                eti_pkg::CFG_ESCAPE_BOUND:
                begin
                    bound_next = cfg_data[eti_pkg::BOUND_W-1:0];
                end
                default:
                begin
                    max_iter_next = max_iter_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= eti_pkg::MAX_ITER_RESET;
            bound_reg    <= eti_pkg::BOUND_RESET;
        end
        else
        begin
            max_iter_reg <= max_iter_next;
            bound_reg    <= bound_next;
        end
    end

    eti_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .start_real     (start_real),
        .start_imag     (start_imag),
        .const_real     (const_real),
        .const_imag     (const_imag),
        .max_iterations (max_iter_reg),
        .q_status       (q_status),
        .push           (push),
        .push_item      (push_item)
    );

    eti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (q_head),
        .status    (q_status)
    );

    eti_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .q_head         (q_head),
        .pop            (pop),
        .max_iterations (max_iter_reg),
        .escape_bound   (bound_reg),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .escape_count   (escape_count)
    );

    // Front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
        else $error("push into full queue");

    // Engine never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A delivered count never exceeds the iteration limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (escape_count <= max_iter_reg))
        else $error("escape count above limit");

    // A stalled result beat stays up and keeps its count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(escape_count)))
        else $error("stalled result changed");

endmodule

@@ sv/eti_front.sv @@
module eti_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_stall,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]     start_real,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]     start_imag,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]     const_real,
    input  logic signed [eti_pkg::DATA_WIDTH-1:0]     const_imag,
    input  logic [eti_pkg::COUNT_WIDTH-1:0]           max_iterations,
    input  eti_pkg::eti_q_status_t                    q_status,
    output logic                                      push,
    output eti_pkg::eti_item_t                        push_item
);

    logic               valid_reg;
    logic               valid_next;
    eti_pkg::eti_item_t item_reg;
    logic               accept;

    // Stall only when a beat is held and the queue cannot take it
    assign item_stall = valid_reg && q_status.full;
    assign accept     = item_valid && !item_stall;
    assign push       = valid_reg && !q_status.full;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture and classify the incoming beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.start_real <= start_real;
            item_reg.start_imag <= start_imag;
            item_reg.const_real <= const_real;
            item_reg.const_imag <= const_imag;
            item_reg.zero_limit <= (max_iterations == '0);
        end
    end

endmodule

@@ sv/eti_queue.sv @@
module eti_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  eti_pkg::eti_item_t     push_item,
    input  logic                   pop,
    output eti_pkg::eti_item_t     head,
    output eti_pkg::eti_q_status_t status
);

    eti_pkg::eti_item_t              entry_reg [eti_pkg::Q_DEPTH];
    logic [eti_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [eti_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [eti_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [eti_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [eti_pkg::Q_CNT_W-1:0]     fill_reg;
    logic [eti_pkg::Q_CNT_W-1:0]     fill_next;

    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == eti_pkg::Q_CNT_W'(eti_pkg::Q_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and fill update, wrapping at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == eti_pkg::Q_PTR_W'(eti_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == eti_pkg::Q_PTR_W'(eti_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/eti_engine.sv @@
module eti_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  eti_pkg::eti_q_status_t             q_status,
    input  eti_pkg::eti_item_t                 q_head,
    output logic                               pop,
    input  logic [eti_pkg::COUNT_WIDTH-1:0]    max_iterations,
    input  logic [eti_pkg::BOUND_W-1:0]        escape_bound,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [eti_pkg::COUNT_WIDTH-1:0]    escape_count
);

    eti_pkg::eng_state_t state_reg;
    eti_pkg::eng_state_t state_next;

    logic signed [eti_pkg::DATA_WIDTH-1:0] zr_reg, zr_next;
    logic signed [eti_pkg::DATA_WIDTH-1:0] zi_reg, zi_next;
    logic signed [eti_pkg::DATA_WIDTH-1:0] cr_reg, cr_next;
    logic signed [eti_pkg::DATA_WIDTH-1:0] ci_reg, ci_next;
    logic [eti_pkg::COUNT_WIDTH-1:0]       count_reg, count_next;
    logic signed [eti_pkg::PROD_W-1:0]     p_rr_reg, p_ii_reg, p_ri_reg;
    logic signed [eti_pkg::PROD_W-1:0]     p_rr_next, p_ii_next, p_ri_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [eti_pkg::COUNT_WIDTH-1:0]       out_count_reg, out_count_next;

    logic [eti_pkg::MAG_W-1:0]             mag_sum;
    logic [eti_pkg::MAG_W-1:0]             mag;
    logic                                  escaped;
    logic                                  keep_going;
    logic signed [eti_pkg::PROD_W-1:0]     rr_s, ii_s;
    logic signed [eti_pkg::PROD_W:0]       ri2;
    logic signed [eti_pkg::PROD_W:0]       ri2_s;
    logic signed [eti_pkg::SUM_W-1:0]      sum_r, sum_i;
    logic signed [eti_pkg::DATA_WIDTH-1:0] new_r, new_i;
    logic                                  out_free;

    assign result_valid = out_valid_reg;
    assign escape_count = out_count_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    // Squares and cross product of the current z
    assign p_rr_next = zr_reg * zr_reg;
    assign p_ii_next = zi_reg * zi_reg;
    assign p_ri_next = zr_reg * zi_reg;

    // Escape test on the registered squares
    assign mag_sum    = {1'b0, p_rr_reg} + {1'b0, p_ii_reg};
    assign mag        = mag_sum >> eti_pkg::FRAC_BITS;
    assign escaped    = mag > eti_pkg::MAG_W'(escape_bound);
    assign keep_going = (count_reg < max_iterations) && !escaped;

    // Next z: scale back, add c, clamp
    assign rr_s  = p_rr_reg >>> eti_pkg::FRAC_BITS;
    assign ii_s  = p_ii_reg >>> eti_pkg::FRAC_BITS;
    assign ri2   = $signed({p_ri_reg, 1'b0});
    assign ri2_s = ri2 >>> eti_pkg::FRAC_BITS;
    assign sum_r = eti_pkg::SUM_W'(rr_s) - eti_pkg::SUM_W'(ii_s) + eti_pkg::SUM_W'(cr_reg);
    assign sum_i = eti_pkg::SUM_W'(ri2_s) + eti_pkg::SUM_W'(ci_reg);
    assign new_r = eti_pkg::sat_data(sum_r);
    assign new_i = eti_pkg::sat_data(sum_i);

    // Sequencer: load, multiply, update, deliver
    always_comb
    begin
        state_next     = state_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        count_next     = count_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && result_stall;
        out_count_next = out_count_reg;
        unique case (state_reg)
            eti_pkg::ENG_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (q_head.zero_limit)
                    begin
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_count_next = '0;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        zr_next    = q_head.start_real;
                        zi_next    = q_head.start_imag;
                        cr_next    = q_head.const_real;
                        ci_next    = q_head.const_imag;
                        count_next = '0;
                        state_next = eti_pkg::ENG_MUL;
                    end
                end
            end
            eti_pkg::ENG_MUL:
            begin
                state_next = eti_pkg::ENG_STEP;
            end
            eti_pkg::ENG_STEP:
            begin
                if (keep_going)
                begin
                    zr_next    = new_r;
                    zi_next    = new_i;
                    count_next = count_reg + 1'b1;
                    state_next = eti_pkg::ENG_MUL;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = eti_pkg::ENG_IDLE;
                end
                else
                begin
                    state_next = eti_pkg::ENG_WAIT;
                end
            end
            eti_pkg::ENG_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = eti_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = eti_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eti_pkg::ENG_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
        if (state_reg == eti_pkg::ENG_MUL)
        begin
            p_rr_reg <= p_rr_next;
            p_ii_reg <= p_ii_next;
            p_ri_reg <= p_ri_next;
        end
    end

endmodule
